### rtl/core/bgre_pkg.sv
package bgre_pkg;

	// Glyphs held in the character ROM.
	typedef enum logic [1:0] {
		GLYPH_E,
		GLYPH_H,
		GLYPH_L,
		GLYPH_O
	} glyph_t;

	// Character codes that select a glyph.
	localparam logic [7:0] CHAR_E = 8'h65;
	localparam logic [7:0] CHAR_H = 8'h68;
	localparam logic [7:0] CHAR_L = 8'h6C;
	localparam logic [7:0] CHAR_O = 8'h6F;

	// Configuration register indexes.
	localparam logic REG_PIXEL_SCALE = 1'b0;
	localparam logic REG_DRAW_COLOR  = 1'b1;

	localparam logic [7:0] PIXEL_SCALE_RESET = 8'd1;
	localparam logic [31:0] DRAW_COLOR_RESET = 32'd0;

	// Leftmost pixel of a glyph row.
	localparam logic [7:0] LEFT_BIT = 8'h80;

	// Row 0 is the top row; bit 7 of a row is its leftmost pixel.
	typedef logic [0:7][7:0] glyph_rom_t;

	localparam glyph_rom_t ROM_E = {8'h00, 8'h00, 8'h3C, 8'h66, 8'h7E, 8'h60, 8'h3C, 8'h00};
	localparam glyph_rom_t ROM_H = {8'h60, 8'h60, 8'h7C, 8'h66, 8'h66, 8'h66, 8'h66, 8'h00};
	localparam glyph_rom_t ROM_L = {8'h38, 8'h18, 8'h18, 8'h18, 8'h18, 8'h18, 8'h3C, 8'h00};
	localparam glyph_rom_t ROM_O = {8'h00, 8'h00, 8'h3C, 8'h66, 8'h66, 8'h66, 8'h3C, 8'h00};

	// Status of the queue between the front and back ends.
	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [7:0] glyph_row(glyph_t g, logic [2:0] r);
		logic [7:0] bits;
		unique case (g)
			GLYPH_E: bits = ROM_E[r];
			GLYPH_H: bits = ROM_H[r];
			GLYPH_L: bits = ROM_L[r];
			GLYPH_O: bits = ROM_O[r];
			default: bits = '0;
		endcase
		return bits;
	endfunction

	// Topmost row with a lit pixel.
	function automatic logic [2:0] first_row(glyph_t g);
		logic [2:0] fr;
		logic found;
		fr = '0;
		found = 1'b0;
		for (int r = 0; r < 8; r++) begin
			if (!found && glyph_row(g, 3'(r)) != '0) begin
				fr = 3'(r);
				found = 1'b1;
			end
		end
		return fr;
	endfunction

	// Bottom row with a lit pixel.
	function automatic logic [2:0] last_row(glyph_t g);
		logic [2:0] lr;
		lr = '0;
		for (int r = 0; r < 8; r++) begin
			if (glyph_row(g, 3'(r)) != '0) begin
				lr = 3'(r);
			end
		end
		return lr;
	endfunction

	// Column of the leftmost lit pixel in a row.
	function automatic logic [2:0] lead_col(logic [7:0] bits);
		logic [2:0] col;
		col = '0;
		for (int i = 7; i >= 0; i--) begin
			if (bits[7 - i]) begin
				col = 3'(i);
			end
		end
		return col;
	endfunction

endpackage

### rtl/core/bgre_front.sv
module bgre_front #(
	parameter int CW = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   char_code,
	input  logic                         string_start,
	input  logic signed [15:0]           start_x,
	input  logic signed [15:0]           row_y,
	input  logic [7:0]                   scale,
	input  bgre_pkg::q_status_t          q_stat,
	output logic                         q_push,
	output logic [2*CW+1:0]              q_wdata
);
	import bgre_pkg::*;

	logic [CW-1:0] cursor_q;
	logic [CW-1:0] x_base;
	logic          accept;
	logic          known;
	glyph_t        glyph;

	assign in_stall = q_stat.full;
	assign accept   = in_valid && !q_stat.full;
	assign x_base   = string_start ? start_x[CW-1:0] : cursor_q;

	always_comb begin
		known = 1'b1;
		glyph = GLYPH_E;
		unique case (char_code)
			CHAR_E: glyph = GLYPH_E;
			CHAR_H: glyph = GLYPH_H;
			CHAR_L: glyph = GLYPH_L;
			CHAR_O: glyph = GLYPH_O;
			default: known = 1'b0;
		endcase
	end

	// A zero scale draws nothing, so such characters never reach the back end.
	assign q_push  = accept && known && (scale != '0);
	assign q_wdata = {glyph, x_base, row_y[CW-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_q <= '0;
		end else if (accept) begin
			cursor_q <= x_base + CW'({scale, 3'b000});
		end
	end

endmodule

### rtl/core/bgre_queue.sv
module bgre_queue #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic [WIDTH-1:0]    wdata,
	input  logic                pop,
	output logic [WIDTH-1:0]    rdata,
	output bgre_pkg::q_status_t stat
);
	import bgre_pkg::*;

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [NW-1:0]    count_q;

	assign rdata      = mem_q[rd_ptr_q];
	assign stat.full  = (count_q == NW'(DEPTH));
	assign stat.empty = (count_q == '0);

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

### rtl/core/bgre_back.sv
module bgre_back #(
	parameter int CW = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          scale,
	input  logic [31:0]         color,
	input  bgre_pkg::q_status_t q_stat,
	input  logic [2*CW+1:0]     q_rdata,
	output logic                q_pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic [15:0]         rect_x,
	output logic [15:0]         rect_y,
	output logic [7:0]          rect_size,
	output logic [31:0]         rect_color,
	output logic                last_of_char
);
	import bgre_pkg::*;

	logic          busy_q;
	logic          out_valid_q;
	glyph_t        glyph_q;
	logic [2:0]    row_q;
	logic [7:0]    bits_q;
	logic [CW-1:0] xb_q;
	logic [CW-1:0] yrow_q;

	glyph_t        ld_glyph;
	logic [2:0]    ld_row;
	logic [10:0]   ld_prod;
	logic          can_go;
	logic          emit;
	logic          last;
	logic          row_done;
	logic [2:0]    col;
	logic [7:0]    bits_nx;
	logic [10:0]   col_prod;

	assign ld_glyph = glyph_t'(q_rdata[2*CW+1 -: 2]);
	assign ld_row   = first_row(ld_glyph);
	assign ld_prod  = 11'(ld_row) * 11'(scale);
	assign q_pop    = !busy_q && !q_stat.empty;

	assign can_go   = !out_valid_q || !out_stall;
	assign col      = lead_col(bits_q);
	assign bits_nx  = bits_q & ~(LEFT_BIT >> col);
	assign col_prod = 11'(col) * 11'(scale);
	assign emit     = busy_q && can_go && (bits_q != '0);
	assign last     = (bits_nx == '0) && (row_q == last_row(glyph_q));
	// Move to the next row after its last lit pixel, or straight away on an empty row.
	assign row_done = busy_q && can_go && (bits_q == '0 || (bits_nx == '0 && !last));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (q_pop) begin
				busy_q <= 1'b1;
			end else if (emit && last) begin
				busy_q <= 1'b0;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			glyph_q <= ld_glyph;
			row_q   <= ld_row;
			bits_q  <= glyph_row(ld_glyph, ld_row);
			xb_q    <= q_rdata[2*CW-1 -: CW];
			yrow_q  <= q_rdata[CW-1:0] + CW'(ld_prod);
		end else if (row_done) begin
			row_q  <= row_q + 1'b1;
			bits_q <= glyph_row(glyph_q, row_q + 1'b1);
			yrow_q <= yrow_q + CW'(scale);
		end else if (emit) begin
			bits_q <= bits_nx;
		end
		if (emit) begin
			rect_x       <= 16'(xb_q + CW'(col_prod));
			rect_y       <= 16'(yrow_q);
			rect_size    <= scale;
			rect_color   <= color;
			last_of_char <= last;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/core/bitmap_glyph_rect_emitter.sv
// Bitmap glyph rectangle emitter. Each input request carries one character; the block keeps a
// horizontal cursor (reloaded from start_x when string_start is set) and, for the four glyphs in
// its 8x8 ROM ('e', 'h', 'l' and 'o'), sends one square rectangle per lit pixel, top row first
// and left to right, at cursor + column * pixel_scale and row_y + row * pixel_scale, with side
// pixel_scale and colour draw_color. last_of_char marks the final rectangle of a character.
// Unknown characters send nothing but still move the cursor by 8 * pixel_scale; a scale of zero
// sends nothing and leaves the cursor where it is. Coordinates wrap modulo 2^min(COORD_BITS, 16).
// Timing: the front end takes one character a cycle while its two-entry queue has room. The
// back end takes a character from the queue only once it has finished the last one, then
// sends one rectangle per lit pixel through the single rectangle output port, stepping over
// blank rows between lit rows and holding while out_stall is set. Unknown characters and a
// zero scale only pass through the front end and never reach the back end. Configuration is
// written through cfg_we, cfg_index and cfg_data while the block is idle; there is no
// clearing pass after reset.
module bitmap_glyph_rect_emitter #(
	parameter int COORD_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [7:0]         char_code,
	input  logic               string_start,
	input  logic signed [15:0] start_x,
	input  logic signed [15:0] row_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [15:0]        rect_x,
	output logic [15:0]        rect_y,
	output logic [7:0]         rect_size,
	output logic [31:0]        rect_color,
	output logic               last_of_char
);
	import bgre_pkg::*;

	// Outputs keep only their low 16 bits, so coordinates never need more than that.
	localparam int CW = (COORD_BITS < 16) ? COORD_BITS : 16;
	localparam int QW = 2 * CW + 2;

	logic [7:0]  pixel_scale_q;
	logic [31:0] draw_color_q;

	q_status_t   q_stat;
	logic        q_push;
	logic        q_pop;
	logic [QW-1:0] q_wdata;
	logic [QW-1:0] q_rdata;

	// Configuration registers. Writes must only happen while the block is idle; the block does
	// not enforce this itself. Given that, both ends read them directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pixel_scale_q <= PIXEL_SCALE_RESET;
			draw_color_q  <= DRAW_COLOR_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PIXEL_SCALE: pixel_scale_q <= cfg_data[7:0];
				REG_DRAW_COLOR:  draw_color_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	// The front end owns the cursor and decides which characters need drawing.
	bgre_front #(
		.CW(CW)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.char_code    (char_code),
		.string_start (string_start),
		.start_x      (start_x),
		.row_y        (row_y),
		.scale        (pixel_scale_q),
		.q_stat       (q_stat),
		.q_push       (q_push),
		.q_wdata      (q_wdata)
	);

	// Each queue entry holds a glyph with its resolved left x and top y.
	bgre_queue #(
		.WIDTH(QW),
		.DEPTH(2)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.pop    (q_pop),
		.rdata  (q_rdata),
		.stat   (q_stat)
	);

	// The back end walks the glyph rows and sends one rectangle per lit pixel.
	bgre_back #(
		.CW(CW)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.scale        (pixel_scale_q),
		.color        (draw_color_q),
		.q_stat       (q_stat),
		.q_rdata      (q_rdata),
		.q_pop        (q_pop),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.rect_x       (rect_x),
		.rect_y       (rect_y),
		.rect_size    (rect_size),
		.rect_color   (rect_color),
		.last_of_char (last_of_char)
	);

`ifndef SYNTH
	a_no_push_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_stat.full)
		else $error("queue written while full");

	a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !q_stat.empty)
		else $error("queue read while empty");

	a_rect_size_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (rect_size != '0))
		else $error("rectangle sent with zero size");
`endif

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
	import bgre_pkg::*;

	// Time allowed after the last expected rectangle before the block counts as idle. A request
	// that draws nothing only passes through the front end, and a full glyph has at most 25 lit
	// pixels, so this is comfortably more than anything still in flight.
	localparam int SETTLE_CYCLES = 64;
	// The slowest correct run is roughly 240 requests, each drawing 25 rectangles that wait
	// out the longest receiver stall, plus sender gaps. This limit allows several times that.
	localparam int CYCLE_LIMIT = 500000;
	localparam int ITEMS_PER_PHASE = 32;
	localparam int PHASES = 7;

	// One rectangle as the block should present it.
	typedef struct packed {
		logic [15:0] px;
		logic [15:0] py;
		logic [7:0]  side;
		logic [31:0] color;
		logic        last;
	} rect_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = REG_PIXEL_SCALE;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  char_code = '0;
	logic        string_start = 1'b0;
	logic [15:0] start_x = '0;
	logic [15:0] row_y = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [15:0] rect_x;
	logic [15:0] rect_y;
	logic [7:0]  rect_size;
	logic [31:0] rect_color;
	logic        last_of_char;

	// Our own view of the block's state: the pen position and both registers.
	logic [15:0] pen_x = '0;
	logic [7:0]  scale_reg = PIXEL_SCALE_RESET;
	logic [31:0] color_reg = DRAW_COLOR_RESET;

	// Rectangles predicted from accepted requests, oldest first.
	rect_t pending_rects[$];

	int fails = 0;
	int cycles = 0;
	int burst_left = 0;
	int stall_left = 0;
	bit sender_gaps = 1'b1;
	bit receiver_stalls = 1'b1;

	logic [7:0] known_codes[4] = '{CHAR_E, CHAR_H, CHAR_L, CHAR_O};

	bitmap_glyph_rect_emitter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.char_code(char_code),
		.string_start(string_start),
		.start_x(start_x),
		.row_y(row_y),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.rect_x(rect_x),
		.rect_y(rect_y),
		.rect_size(rect_size),
		.rect_color(rect_color),
		.last_of_char(last_of_char)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Watchdog: a hung handshake or a lost rectangle ends the run here.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: timed out with %0d rectangles outstanding", $time,
				pending_rects.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Row of the glyph that a character code selects; codes outside the ROM read as blank rows.
	function automatic logic [7:0] glyph_bits(input logic [7:0] code, input int row);
		case (code)
			CHAR_E: return ROM_E[row];
			CHAR_H: return ROM_H[row];
			CHAR_L: return ROM_L[row];
			CHAR_O: return ROM_O[row];
			default: return 8'h00;
		endcase
	endfunction

	// Works out every rectangle that one accepted request draws and moves the pen on. The last
	// lit pixel found is held back so that it can carry the end-of-character flag.
	task automatic predict_glyph_rects(input logic [7:0] code, input logic start,
			input logic [15:0] sx, input logic [15:0] y);
		rect_t held;
		rect_t r;
		logic have;
		logic [7:0] bits;
		have = 1'b0;
		held = '0;
		if (start) begin
			pen_x = sx;
		end
		// A zero scale draws nothing and leaves the pen where the reload put it.
		if (scale_reg == 8'd0) begin
			return;
		end
		for (int row = 0; row < 8; row++) begin
			bits = glyph_bits(code, row);
			for (int col = 0; col < 8; col++) begin
				if (bits[7 - col]) begin
					r.px = pen_x + 16'(col * scale_reg);
					r.py = y + 16'(row * scale_reg);
					r.side = scale_reg;
					r.color = color_reg;
					r.last = 1'b0;
					if (have) begin
						pending_rects.push_back(held);
					end
					held = r;
					have = 1'b1;
				end
			end
		end
		if (have) begin
			held.last = 1'b1;
			pending_rects.push_back(held);
		end
		// Unknown characters still move the pen by a full cell.
		pen_x = pen_x + 16'(8 * scale_reg);
	endtask

	// Every request that the block takes is predicted at the edge that takes it.
	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall) begin
			predict_glyph_rects(char_code, string_start, start_x, row_y);
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s expected %h, got %h", $time, what, want, got);
			fails++;
		end
	endtask

	// Each rectangle taken from the block is compared with the oldest prediction.
	always @(posedge clk) begin : check_rects
		rect_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_rects.size() == 0) begin
				$display("%0t ns: rectangle x=%h y=%h arrived with none expected, expected none",
					$time, rect_x, rect_y);
				fails++;
			end else begin
				want = pending_rects.pop_front();
				check_field("rect_x", 32'(want.px), 32'(rect_x));
				check_field("rect_y", 32'(want.py), 32'(rect_y));
				check_field("rect_size", 32'(want.side), 32'(rect_size));
				check_field("rect_color", want.color, rect_color);
				check_field("last_of_char", 32'(want.last), 32'(last_of_char));
			end
		end
	end

	// The receiver stalls in runs of random length, starting at random, so that stalls land
	// on the first, middle and last rectangle of a character alike.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else if (receiver_stalls && $urandom_range(0, 3) == 0) begin
			out_stall <= 1'b1;
			stall_left = $urandom_range(0, 9);
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Sends one request and returns at the edge that accepts it. The sender works in bursts;
	// between bursts it drops valid for a gap that is mostly short and sometimes long enough
	// to let the back end run dry.
	task automatic send_char(input logic [7:0] code, input logic start,
			input logic [15:0] sx, input logic [15:0] y);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = 0;
			if (sender_gaps) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 40) : $urandom_range(0, 5);
			end
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		char_code <= code;
		string_start <= start;
		start_x <= sx;
		row_y <= y;
		do @(posedge clk); while (!(in_valid && !in_stall));
	endtask

	// Stops sending and waits until the block has nothing left to do, so that the registers
	// may be written.
	task automatic settle();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_rects.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Register write; the block takes it at the next edge, and our copy follows at that edge.
	// The enable drops for one cycle afterwards so that back-to-back writes stay apart.
	task automatic write_reg(input logic idx, input logic [31:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_PIXEL_SCALE) begin
			scale_reg = data[7:0];
		end else begin
			color_reg = data;
		end
		@(posedge clk);
	endtask

	// With the registers as reset left them (scale one, colour zero), draw a short word.
	task automatic test_reset_defaults();
		send_char(CHAR_H, 1'b1, 16'd10, 16'd20);
		send_char(CHAR_E, 1'b0, 16'h0000, 16'd20);
		send_char(CHAR_L, 1'b0, 16'hFFFF, 16'd20);
		send_char(CHAR_L, 1'b0, 16'h0000, 16'd20);
		send_char(CHAR_O, 1'b0, 16'hFFFF, 16'd20);
	endtask

	// Largest scale and an all-ones colour at the edges of the coordinate range, so that both
	// axes wrap, followed by unknown codes (zero, all ones and a neighbour of a ROM code) that
	// must still move the pen.
	task automatic test_glyph_extremes();
		settle();
		write_reg(REG_PIXEL_SCALE, 32'hFFFF_FFFF);
		write_reg(REG_DRAW_COLOR, 32'hFFFF_FFFF);
		send_char(CHAR_O, 1'b1, 16'h7FFF, 16'h7FFF);
		send_char(CHAR_L, 1'b1, 16'h8000, 16'h8000);
		send_char(CHAR_E, 1'b0, 16'h0000, 16'hFFFF);
		send_char(CHAR_H, 1'b0, 16'h0000, 16'h0000);
		send_char(8'h00, 1'b0, 16'h0000, 16'h0000);
		send_char(8'hFF, 1'b0, 16'hFFFF, 16'hFFFF);
		send_char(8'h6D, 1'b0, 16'h0000, 16'h0000);
		send_char(CHAR_E, 1'b0, 16'h0000, 16'h1234);
	endtask

	// A zero scale draws nothing and holds the pen, but a string start still reloads it; the
	// next glyph at scale one must appear at the reloaded position.
	task automatic test_zero_scale();
		settle();
		write_reg(REG_PIXEL_SCALE, 32'h0000_0000);
		write_reg(REG_DRAW_COLOR, 32'hA5A5_5A5A);
		send_char(CHAR_H, 1'b1, 16'd100, 16'd40);
		send_char(8'h78, 1'b0, 16'h0000, 16'd40);
		settle();
		write_reg(REG_PIXEL_SCALE, 32'h0000_0001);
		send_char(CHAR_O, 1'b0, 16'h0000, 16'd40);
	endtask

	// Random phases, each under its own register setting. Most requests form strings of ROM
	// glyphs that open with a string start on a shared row; the rest are noise with random
	// codes and random start flags. One phase runs with no idling on either side.
	task automatic test_random_strings();
		int sent;
		int len;
		logic [7:0] code;
		logic [7:0] scale;
		logic [15:0] line_y;
		logic [31:0] colour;
		for (int phase = 0; phase < PHASES; phase++) begin
			settle();
			case (phase)
				0: scale = 8'd1;
				1: scale = 8'd2;
				2: scale = 8'd255;
				3: scale = 8'd3;
				4: scale = 8'd0;
				5: scale = 8'($urandom_range(4, 16));
				default: scale = 8'($urandom_range(1, 255));
			endcase
			case (phase)
				0: colour = 32'h0000_0000;
				2: colour = 32'hFFFF_FFFF;
				default: colour = $urandom;
			endcase
			// The upper bits of a scale write carry random junk that the block must ignore.
			write_reg(REG_PIXEL_SCALE, {24'($urandom), scale});
			write_reg(REG_DRAW_COLOR, colour);
			sender_gaps = (phase != 3);
			receiver_stalls = (phase != 3);
			sent = 0;
			while (sent < ITEMS_PER_PHASE) begin
				if ($urandom_range(0, 9) == 0) begin
					send_char(8'($urandom), 1'($urandom), 16'($urandom), 16'($urandom));
					sent++;
				end else begin
					len = $urandom_range(1, 8);
					line_y = 16'($urandom);
					for (int k = 0; k < len && sent < ITEMS_PER_PHASE; k++) begin
						code = ($urandom_range(0, 6) == 0) ? 8'($urandom)
							: known_codes[$urandom_range(0, 3)];
						send_char(code, k == 0, 16'($urandom), line_y);
						sent++;
					end
				end
			end
		end
		sender_gaps = 1'b1;
		receiver_stalls = 1'b1;
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_glyph_extremes();
		test_zero_scale();
		test_random_strings();
		settle();
		if (fails == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
